// File: sv/multi_queue_shared_buffer_assert.svh
// Assertion macros for the multi-queue shared buffer RTL.
`ifndef MULTI_QUEUE_SHARED_BUFFER_ASSERT_SVH
`define MULTI_QUEUE_SHARED_BUFFER_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define MQSB_ASSERT(label, clk_s, rst_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define MQSB_ASSERT_ALWAYS(label, clk_s, prop, msg) \
    label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// File: sv/mqsb_pkg.sv
// Package: operation and status codes and fixed port widths of the shared buffer.
`timescale 1ns / 1ps
`default_nettype none

package mqsb_pkg;

    localparam int QID_W   = 3;
    localparam int VALUE_W = 32;

    typedef enum logic
    {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } mode_t;

    typedef enum logic [1:0]
    {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

endpackage

`default_nettype wire

// File: sv/mqsb_ram.sv
// Simple dual-port RAM: one write, one registered read, write-first on address match.
`timescale 1ns / 1ps
`default_nettype none

module mqsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_mem_reg;
    logic [WIDTH-1:0] byp_data_reg;
    logic             byp_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_mem_reg   <= mem[raddr];
            byp_data_reg <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (re)
        begin
            byp_reg <= we && (waddr == raddr);
        end
    end

    assign rdata = byp_reg ? byp_data_reg : rd_mem_reg;

endmodule

`default_nettype wire

// File: sv/multi_queue_shared_buffer.sv
// Top level: several FIFO queues linked through one shared slot store with a free list.
//
// Usage:
//   Input channel (in_valid/in_ready) carries mode, queue_id and value. A push
//   appends value to queue queue_id; a pop removes that queue's oldest word.
//   Output channel (out_valid/out_ready) returns one status/data_out transfer
//   per input transfer, in order: DONE, FULL (push with no free slot or bad
//   queue id) or EMPTY (pop of an empty queue or bad queue id). data_out holds
//   the popped word on a successful pop and zero otherwise.
//   Order: the input transfer loads the input stage and issues the slot-memory
//   reads; the input stage then passes its item into the result register, but
//   not while a result held there has not been taken.
//   Throughput: one item per cycle while out_ready stays high. The next
//   item's read address comes from the link word read for the item in
//   flight, muxed straight into the registered-read port of the link memory.
//   Reset: all queues empty, free list chains every slot in order. A fill
//   count stands in for the link memory's initial contents, so the block
//   takes items straight after reset.
//   Stall: while out_ready is low a valid result holds in the result register,
//   the input stage then holds, and in_ready drops once both are occupied.
`timescale 1ns / 1ps
`default_nettype none

module multi_queue_shared_buffer #(
    parameter int SLOTS      = 64,
    parameter int QUEUES     = 8,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire mqsb_pkg::mode_t               mode,
    input  wire logic [mqsb_pkg::QID_W-1:0]    queue_id,
    input  wire logic signed [mqsb_pkg::VALUE_W-1:0] value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output mqsb_pkg::status_t                  status,
    output logic signed [mqsb_pkg::VALUE_W-1:0] data_out
);

    import mqsb_pkg::*;

    `include "multi_queue_shared_buffer_assert.svh"

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int LINK_W = $clog2(SLOTS + 1);
    localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

    // input stage
    logic                       s1_valid_reg;
    mode_t                      s1_mode_reg;
    logic [QID_W-1:0]           s1_qid_reg;
    logic signed [VALUE_W-1:0]  s1_value_reg;
    logic [IDX_W-1:0]           lrd_addr_reg;
    logic                       lrd_fresh_reg;

    // queue and free-list state
    logic [LINK_W-1:0]          queue_head_reg [QUEUES];
    logic [IDX_W-1:0]           queue_tail_reg [QUEUES];
    logic [LINK_W-1:0]          free_head_reg;
    logic [LINK_W-1:0]          free_head_next;
    logic [LINK_W-1:0]          fill_reg;
    logic [LINK_W-1:0]          fill_next;

    // result register
    logic                       out_valid_reg;
    status_t                    status_reg;
    logic signed [VALUE_W-1:0]  data_out_reg;

    // execute stage
    logic                       exec;
    logic                       accept;
    logic [QIDX_W-1:0]          qx;
    logic                       q_ok;
    logic [LINK_W-1:0]          head;
    logic [LINK_W-1:0]          link_rdata;
    logic [LINK_W-1:0]          link_rd;
    logic [DATA_WIDTH-1:0]      data_rdata;
    logic signed [DATA_WIDTH-1:0] data_rd_s;
    logic                       head_we;
    logic [LINK_W-1:0]          head_wdata;
    logic                       tail_we;
    logic [IDX_W-1:0]           tail_wdata;
    logic                       link_we;
    logic [IDX_W-1:0]           link_waddr;
    logic [LINK_W-1:0]          link_wdata;
    logic                       data_we;
    logic [IDX_W-1:0]           data_waddr;
    logic [DATA_WIDTH-1:0]      data_wdata;
    status_t                    status_next;
    logic signed [VALUE_W-1:0]  data_out_next;

    // read issue
    logic [QIDX_W-1:0]          qin;
    logic [LINK_W-1:0]          head_in;
    logic [LINK_W-1:0]          link_raddr;

    assign exec     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || exec;
    assign accept   = in_valid && in_ready;

    assign qx        = QIDX_W'(s1_qid_reg);
    assign q_ok      = 32'(s1_qid_reg) < QUEUES;
    assign head      = queue_head_reg[qx];
    assign data_rd_s = data_rdata;

    // never-written link entries read as their reset chain i -> i+1
    assign link_rd = lrd_fresh_reg ? link_rdata : (LINK_W'(lrd_addr_reg) + LINK_W'(1));

    always_comb
    begin
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        head_we        = 1'b0;
        head_wdata     = head;
        tail_we        = 1'b0;
        tail_wdata     = free_head_reg[IDX_W-1:0];
        link_we        = 1'b0;
        link_waddr     = queue_tail_reg[qx];
        link_wdata     = free_head_reg;
        data_we        = 1'b0;
        data_waddr     = free_head_reg[IDX_W-1:0];
        data_wdata     = DATA_WIDTH'(s1_value_reg);
        status_next    = STATUS_DONE;
        data_out_next  = '0;
        unique case (s1_mode_reg)
            MODE_PUSH:
            begin
                if (!q_ok || (free_head_reg == NIL))
                begin
                    status_next = STATUS_FULL;
                end
                else if (exec)
                begin
                    free_head_next = link_rd;
                    if (free_head_reg == fill_reg)
                    begin
                        fill_next = fill_reg + LINK_W'(1);
                    end
                    if (head == NIL)
                    begin
                        head_we    = 1'b1;
                        head_wdata = free_head_reg;
                    end
                    else
                    begin
                        link_we = 1'b1;
                    end
                    tail_we = 1'b1;
                    data_we = 1'b1;
                end
            end
            MODE_POP:
            begin
                if (!q_ok || (head == NIL))
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    data_out_next = VALUE_W'(data_rd_s);
                    if (exec)
                    begin
                        head_we        = 1'b1;
                        // last entry: the tail's link was never set
                        head_wdata     = (head[IDX_W-1:0] == queue_tail_reg[qx]) ? NIL : link_rd;
                        link_we        = 1'b1;
                        link_waddr     = head[IDX_W-1:0];
                        link_wdata     = free_head_reg;
                        free_head_next = head;
                    end
                end
            end
            default:
            begin
                status_next = STATUS_DONE;
            end
        endcase
    end

    // next item's read address sees this cycle's updates
    assign qin     = QIDX_W'(queue_id);
    assign head_in = (head_we && (qin == qx)) ? head_wdata : queue_head_reg[qin];

    always_comb
    begin
        unique case (mode)
            MODE_PUSH: link_raddr = free_head_next;
            MODE_POP:  link_raddr = head_in;
            default:   link_raddr = free_head_next;
        endcase
    end

    mqsb_ram #(
        .WIDTH (LINK_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (accept),
        .raddr (link_raddr[IDX_W-1:0]),
        .rdata (link_rdata)
    );

    mqsb_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (SLOTS)
    ) u_data_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .re    (accept),
        .raddr (head_in[IDX_W-1:0]),
        .rdata (data_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            free_head_reg <= '0;
            fill_reg      <= '0;
            for (int i = 0; i < QUEUES; i++)
            begin
                queue_head_reg[i] <= NIL;
            end
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (exec)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            if (head_we)
            begin
                queue_head_reg[qx] <= head_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg   <= mode;
            s1_qid_reg    <= queue_id;
            s1_value_reg  <= value;
            lrd_addr_reg  <= link_raddr[IDX_W-1:0];
            lrd_fresh_reg <= link_raddr < fill_next;
        end
        if (tail_we)
        begin
            queue_tail_reg[qx] <= tail_wdata;
        end
        if (exec)
        begin
            status_reg   <= status_next;
            data_out_reg <= data_out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data_out  = data_out_reg;

    `MQSB_ASSERT(a_fill_bound, clk, rst_n, fill_reg <= NIL, "fill count beyond slot count")
    `MQSB_ASSERT(a_full_means_filled, clk, rst_n, (free_head_reg == NIL) |-> (fill_reg == NIL), "free list empty with unused slots")
    `MQSB_ASSERT(a_no_data_on_fail, clk, rst_n, (out_valid_reg && (status_reg != STATUS_DONE)) |-> (data_out_reg == '0), "data on failed transfer")
    `MQSB_ASSERT(a_free_head_range, clk, rst_n, (free_head_reg == NIL) || (free_head_reg <= fill_reg), "free head beyond fill count")

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Testbench for the multi-queue shared buffer: directed, fill/drain and random push/pop traffic.
`timescale 1ns / 1ps

module testbench;

    import mqsb_pkg::*;

    localparam int SLOTS       = 64;
    localparam int QUEUES      = 8;
    localparam int DATA_WIDTH  = 32;
    localparam logic [6:0] NIL = 7'd64;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        status_t            status;
        logic signed [31:0] data;
    } result_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    mode_t                       mode;
    logic [QID_W-1:0]            queue_id;
    logic signed [VALUE_W-1:0]   value;
    logic                        out_valid;
    logic                        out_ready;
    status_t                     status;
    logic signed [VALUE_W-1:0]   data_out;

    // buffer model
    logic signed [VALUE_W-1:0]   slot_word [SLOTS];
    logic [6:0]                  next_slot [SLOTS];
    logic [6:0]                  head_slot [QUEUES];
    logic [5:0]                  tail_slot [QUEUES];
    logic [6:0]                  free_ptr;
    int                          queue_depth [QUEUES];
    int                          slots_used;
    int                          peak_used;

    result_t                     awaited_results[$];
    int                          error_count;
    int                          push_total;
    int                          pop_total;
    int                          full_hits;
    int                          empty_hits;
    int                          gap_max;
    int                          ready_max;
    int                          idle_cycles;

    multi_queue_shared_buffer #(
        .SLOTS      (SLOTS),
        .QUEUES     (QUEUES),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .queue_id  (queue_id),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .data_out  (data_out)
    );

    always #6 clk = ~clk;

    task automatic clear_buffer_model();
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_word[i] = '0;
            next_slot[i] = (i == SLOTS - 1) ? NIL : 7'(i + 1);
        end
        for (int q = 0; q < QUEUES; q++)
        begin
            head_slot[q]   = NIL;
            tail_slot[q]   = '0;
            queue_depth[q] = 0;
        end
        free_ptr   = '0;
        slots_used = 0;
        peak_used  = 0;
    endtask

    task automatic apply_queue_op(input mode_t op, input logic [QID_W-1:0] q,
                                  input logic signed [VALUE_W-1:0] word);
        result_t    r;
        logic [5:0] slot;
        r.status = STATUS_DONE;
        r.data   = '0;
        if (op == MODE_PUSH)
        begin
            push_total++;
            if (free_ptr == NIL)
            begin
                r.status = STATUS_FULL;
                full_hits++;
            end
            else
            begin
                slot     = free_ptr[5:0];
                free_ptr = next_slot[slot];
                if (head_slot[q] == NIL)
                    head_slot[q] = {1'b0, slot};
                else
                    next_slot[tail_slot[q]] = {1'b0, slot};
                next_slot[slot] = NIL;
                tail_slot[q]    = slot;
                slot_word[slot] = word;
                queue_depth[q]++;
                slots_used++;
                if (slots_used > peak_used)
                    peak_used = slots_used;
            end
        end
        else
        begin
            pop_total++;
            if (head_slot[q] == NIL)
            begin
                r.status = STATUS_EMPTY;
                empty_hits++;
            end
            else
            begin
                slot            = head_slot[q][5:0];
                head_slot[q]    = next_slot[slot];
                next_slot[slot] = free_ptr;
                free_ptr        = {1'b0, slot};
                r.data          = slot_word[slot];
                queue_depth[q]--;
                slots_used--;
            end
        end
        awaited_results = {awaited_results, r};
    endtask

    task automatic send_op(input mode_t op, input logic [QID_W-1:0] qid,
                           input logic signed [VALUE_W-1:0] word);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        queue_id <= qid;
        value    <= word;
        do @(posedge clk); while (in_ready !== 1'b1);
        apply_queue_op(op, qid, word);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (awaited_results.size() != 0);
    endtask

    function automatic logic signed [VALUE_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [QID_W-1:0] pick_busy_queue();
        int start;
        start = $urandom_range(0, QUEUES - 1);
        for (int k = 0; k < QUEUES; k++)
            if (queue_depth[(start + k) % QUEUES] > 0)
                return QID_W'((start + k) % QUEUES);
        return QID_W'(start);
    endfunction

    task automatic send_random_op(input int push_pct);
        logic [QID_W-1:0] q;
        if ($urandom_range(0, 99) < push_pct)
            send_op(MODE_PUSH, QID_W'($urandom_range(0, QUEUES - 1)), random_word());
        else
        begin
            if ($urandom_range(0, 99) < 85)
                q = pick_busy_queue();
            else
                q = QID_W'($urandom_range(0, QUEUES - 1));
            send_op(MODE_POP, q, $urandom);
        end
    endtask

    task automatic test_corner_ops();
        send_op(MODE_POP,  3'd0, 32'sh1234_5678);
        send_op(MODE_POP,  3'd7, -32'sd1);
        send_op(MODE_PUSH, 3'd0, 32'sh7fff_ffff);
        send_op(MODE_PUSH, 3'd0, 32'sh8000_0000);
        send_op(MODE_PUSH, 3'd7, 32'sh0000_0000);
        send_op(MODE_PUSH, 3'd7, -32'sd1);
        send_op(MODE_PUSH, 3'd3, 32'sh5555_5555);
        send_op(MODE_PUSH, 3'd4, 32'shaaaa_aaaa);
        send_op(MODE_POP,  3'd0, $urandom);
        send_op(MODE_POP,  3'd7, $urandom);
        send_op(MODE_POP,  3'd0, $urandom);
        send_op(MODE_POP,  3'd0, $urandom);
        send_op(MODE_POP,  3'd7, $urandom);
        send_op(MODE_POP,  3'd3, $urandom);
        send_op(MODE_POP,  3'd4, $urandom);
        send_op(MODE_POP,  3'd4, $urandom);
        send_op(MODE_PUSH, 3'd5, 32'sd1);
        send_op(MODE_POP,  3'd5, $urandom);
        send_op(MODE_PUSH, 3'd5, 32'sd2);
        send_op(MODE_PUSH, 3'd6, 32'sd3);
        send_op(MODE_POP,  3'd5, $urandom);
        send_op(MODE_POP,  3'd6, $urandom);
    endtask

    task automatic test_fill_store();
        while (slots_used < SLOTS)
            send_op(MODE_PUSH, QID_W'($urandom_range(0, QUEUES - 1)), random_word());
        send_op(MODE_PUSH, 3'd0, random_word());
        send_op(MODE_PUSH, 3'd7, random_word());
        send_op(MODE_PUSH, QID_W'($urandom_range(0, QUEUES - 1)), random_word());
        send_op(MODE_POP, pick_busy_queue(), $urandom);
        send_op(MODE_PUSH, QID_W'($urandom_range(0, QUEUES - 1)), random_word());
        send_op(MODE_PUSH, QID_W'($urandom_range(0, QUEUES - 1)), random_word());
        wait_for_results();
        for (int q = 0; q < QUEUES; q++)
        begin
            while (queue_depth[q] > 0)
                send_op(MODE_POP, QID_W'(q), $urandom);
            send_op(MODE_POP, QID_W'(q), $urandom);
        end
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_random_op(((i / 40) % 2 == 0) ? 75 : 30);
            if (i == count / 2)
                wait_for_results();
        end
    endtask

    task automatic test_back_to_back(input int count);
        gap_max   = 0;
        ready_max = 0;
        for (int i = 0; i < count; i++)
            send_random_op(55);
        ready_max = 6;
        for (int i = 0; i < count; i++)
            send_random_op(55);
        gap_max = 6;
    endtask

    initial
    begin : result_monitor
        result_t want;
        int      stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, ready_max);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result transfer: status %0d data_out %h", status, data_out);
                error_count++;
            end
            else
            begin
                want = awaited_results[0];
                awaited_results.delete(0);
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
                if (data_out !== want.data)
                begin
                    $error("data_out: expected %h, got %h", want.data, data_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        error_count = 0;
        push_total  = 0;
        pop_total   = 0;
        full_hits   = 0;
        empty_hits  = 0;
        idle_cycles = 0;
        gap_max     = 6;
        ready_max   = 6;
        clear_buffer_model();
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        mode     <= MODE_PUSH;
        queue_id <= '0;
        value    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_corner_ops();
        test_fill_store();
        test_random_mix(230);
        test_back_to_back(30);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            $error("%0d results never arrived", awaited_results.size());
            error_count++;
        end
        $display("covered %0d pushes (%0d refused on a full store), %0d pops (%0d on empty queues)",
                 push_total, full_hits, pop_total, empty_hits);
        $display("peak occupancy %0d of %0d slots, %0d mismatches", peak_used, SLOTS, error_count);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
